[sv/fp32_sign_compare_classify_unit_macros.svh]
// assertion macros for the fp32 sign/compare/classify unit
// no dependencies
`ifndef FP32_SIGN_COMPARE_CLASSIFY_UNIT_MACROS_SVH
`define FP32_SIGN_COMPARE_CLASSIFY_UNIT_MACROS_SVH

// property that must hold on every edge out of reset
`define FSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from one cycle to the next
`define FSC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/fsc_pkg.sv]
// shared types, constants and operation codes for the fp32 sign/compare/classify unit
// no dependencies
package fsc_pkg;

  localparam int unsigned ActionWidth = 4;
  localparam int unsigned WordWidth   = 32;

  typedef enum logic [ActionWidth-1:0] {
    ActSgnj  = 4'd0,
    ActSgnjn = 4'd1,
    ActSgnjx = 4'd2,
    ActMin   = 4'd3,
    ActMax   = 4'd4,
    ActEq    = 4'd5,
    ActLt    = 4'd6,
    ActLe    = 4'd7,
    ActClass = 4'd8
  } action_e;

  localparam logic [WordWidth-1:0] CanonNan = 32'h7fc0_0000;

  typedef struct packed {
    logic [ActionWidth-1:0] action;
    logic [WordWidth-1:0]   operand_a;
    logic [WordWidth-1:0]   operand_b;
  } item_t;

  typedef struct packed {
    logic [WordWidth-1:0] result_word;
    logic                 invalid_flag;
  } result_t;

endpackage

[sv/fsc_datapath.sv]
// combinational execute logic: sign injection, min/max, compares, classify
// depends on fsc_pkg
module fsc_datapath import fsc_pkg::*; (
  input  item_t   item_i,
  output result_t result_o
);

  logic [31:0] a, b, ka, kb;
  logic        an, bn, anysig, both_zero, key_le, key_lt;
  logic [9:0]  cls;
  logic        a_exp_max, a_exp_zero, a_frac_zero;

  assign a  = item_i.operand_a;
  assign b  = item_i.operand_b;
  assign an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  assign bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
  assign anysig = (an && !a[22]) || (bn && !b[22]);
  assign both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
  // monotone keys, -0 below +0
  assign ka = a[31] ? ~a : {1'b1, a[30:0]};
  assign kb = b[31] ? ~b : {1'b1, b[30:0]};
  assign key_le = ka <= kb;
  assign key_lt = ka < kb;

  assign a_exp_max   = a[30:23] == 8'hff;
  assign a_exp_zero  = a[30:23] == 8'h00;
  assign a_frac_zero = a[22:0] == 23'd0;

  always_comb begin
    cls = '0;
    priority if (a_exp_max) begin
      if (a_frac_zero) cls[a[31] ? 0 : 7] = 1'b1;
      else             cls[a[22] ? 9 : 8] = 1'b1;
    end else if (a_exp_zero) begin
      if (a_frac_zero) cls[a[31] ? 3 : 4] = 1'b1;
      else             cls[a[31] ? 2 : 5] = 1'b1;
    end else begin
      cls[a[31] ? 1 : 6] = 1'b1;
    end
  end

  always_comb begin
    result_o = '0;
    unique case (item_i.action)
      ActSgnj:  result_o.result_word = {b[31], a[30:0]};
      ActSgnjn: result_o.result_word = {~b[31], a[30:0]};
      ActSgnjx: result_o.result_word = {a[31] ^ b[31], a[30:0]};
      ActMin, ActMax: begin
        result_o.invalid_flag = anysig;
        priority if (an && bn) result_o.result_word = CanonNan;
        else if (an)           result_o.result_word = b;
        else if (bn)           result_o.result_word = a;
        else if (item_i.action == ActMin) result_o.result_word = key_le ? a : b;
        else                   result_o.result_word = (kb <= ka) ? a : b;
      end
      ActEq: begin
        result_o.invalid_flag = anysig;
        result_o.result_word  = {31'd0, !an && !bn && ((a == b) || both_zero)};
      end
      ActLt: begin
        result_o.invalid_flag = an || bn;
        result_o.result_word  = {31'd0, !an && !bn && !both_zero && key_lt};
      end
      ActLe: begin
        result_o.invalid_flag = an || bn;
        result_o.result_word  = {31'd0, !an && !bn && (both_zero || key_le)};
      end
      ActClass: result_o.result_word = {22'd0, cls};
      default:  result_o = '0;
    endcase
  end

endmodule

[sv/fp32_sign_compare_classify_unit.sv]
// top level of the fp32 sign/compare/classify unit: input and result registers
// depends on fsc_pkg, fsc_datapath and the macros header
`include "fp32_sign_compare_classify_unit_macros.svh"

// RV32F non-arithmetic execute unit: sign injection, min/max, eq/lt/le and
// class on binary32 bit patterns. Each input transfer carries an action code
// and two operands; each produces exactly one result transfer (result word and
// invalid flag). An item is captured in an input register, evaluated by one
// pass of combinational logic and held in a result register, so it passes the
// input register and then the result register before result valid rises; one
// item can enter every cycle while the output is not stalled. Both stages
// advance together whenever the result register is free or being drained, so
// back pressure on the output stalls the input.
module fp32_sign_compare_classify_unit import fsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] action, [35:4] operand_a, [67:36] operand_b, [71:68] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result_word, [32] invalid_flag, [39:33] zero
  output logic [39:0] m_axis_tdata
);

  logic    in_valid_q, out_valid_q;
  item_t   in_q;
  result_t res_d, res_q;
  logic    advance;

  // pipeline moves when the output slot is empty or being taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q  <= s_axis_tvalid;
      out_valid_q <= in_valid_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_q.action    <= s_axis_tdata[3:0];
      in_q.operand_a <= s_axis_tdata[35:4];
      in_q.operand_b <= s_axis_tdata[67:36];
      res_q          <= res_d;
    end
  end

  fsc_datapath u_datapath (
    .item_i   (in_q),
    .result_o (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.invalid_flag, res_q.result_word};

  `FSC_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `FSC_ASSERT_NEXT(a_in_to_out, s_axis_tvalid && s_axis_tready,
    in_valid_q, "accepted item not staged")
  `FSC_ASSERT(a_ready_rule, s_axis_tready == (!m_axis_tvalid || m_axis_tready),
    "ready does not follow output slot")

endmodule

[test/fp32_sign_compare_classify_unit_checker.sv]
// checker for the fp32 sign/compare/classify unit: watches both streams,
// predicts each result and compares it field by field; depends on fsc_pkg
`timescale 1ns / 1ps

module fp32_sign_compare_classify_unit_checker import fsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);

  result_t expected_results_q[$];

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hff) && (x[22:0] != '0);
  endfunction

  function automatic logic is_snan(logic [31:0] x);
    return is_nan(x) && !x[22];
  endfunction

  // monotone ordering key, -0 below +0
  function automatic logic [31:0] order_key(logic [31:0] x);
    return x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

  function automatic logic [31:0] class_mask(logic [31:0] x);
    int pos;
    if (x[30:23] == 8'hff) begin
      if (x[22:0] == '0) pos = x[31] ? 0 : 7;
      else pos = x[22] ? 9 : 8;
    end else if (x[30:23] == 8'h00) begin
      if (x[22:0] == '0) pos = x[31] ? 3 : 4;
      else pos = x[31] ? 2 : 5;
    end else begin
      pos = x[31] ? 1 : 6;
    end
    return 32'd1 << pos;
  endfunction

  function automatic result_t fp_predict(logic [3:0] act, logic [31:0] a, logic [31:0] b);
    result_t r;
    logic an, bn, anysig, zz;
    logic [31:0] ka, kb;
    an = is_nan(a);
    bn = is_nan(b);
    anysig = is_snan(a) || is_snan(b);
    ka = order_key(a);
    kb = order_key(b);
    zz = (a[30:0] == '0) && (b[30:0] == '0);
    r = '0;
    case (act)
      ActSgnj:  r.result_word = {b[31], a[30:0]};
      ActSgnjn: r.result_word = {~b[31], a[30:0]};
      ActSgnjx: r.result_word = {a[31] ^ b[31], a[30:0]};
      ActMin, ActMax: begin
        r.invalid_flag = anysig;
        if (an && bn) r.result_word = CanonNan;
        else if (an) r.result_word = b;
        else if (bn) r.result_word = a;
        else if (act == ActMin) r.result_word = (ka <= kb) ? a : b;
        else r.result_word = (ka >= kb) ? a : b;
      end
      ActEq: begin
        r.invalid_flag = anysig;
        r.result_word = 32'(!an && !bn && (a == b || zz));
      end
      ActLt: begin
        r.invalid_flag = an || bn;
        r.result_word = 32'(!an && !bn && !zz && ka < kb);
      end
      ActLe: begin
        r.invalid_flag = an || bn;
        r.result_word = 32'(!an && !bn && (zz || ka <= kb));
      end
      ActClass: r.result_word = class_mask(a);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_o = expected_results_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results_q.pop_front();
          if (m_axis_tdata[31:0] !== want.result_word ||
              m_axis_tdata[32] !== want.invalid_flag || m_axis_tdata[39:33] !== '0) begin
            $display("%0t: mismatch expected word %h flag %b, got word %h flag %b",
                     $time, want.result_word, want.invalid_flag,
                     m_axis_tdata[31:0], m_axis_tdata[32]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results_q.push_back(fp_predict(s_axis_tdata[3:0], s_axis_tdata[35:4],
                                                s_axis_tdata[67:36]));
    end
  end

endmodule

[test/fp32_sign_compare_classify_unit_tb.sv]
// testbench top for the fp32 sign/compare/classify unit: clock, reset,
// stimulus and verdict; depends on fsc_pkg, the unit and its checker
`timescale 1ns / 1ps

module fp32_sign_compare_classify_unit_tb import fsc_pkg::*;;

  localparam int WatchdogLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [3:0] action, [35:4] operand_a, [67:36] operand_b, [71:68] zero
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] result_word, [32] invalid_flag, [39:33] zero
  logic [39:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  logic        sink_done = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fp32_sign_compare_classify_unit uut (.*);

  fp32_sign_compare_classify_unit_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // interesting binary32 patterns: zeros, infinities, nans, subnormals, extremes
  function automatic logic [31:0] special_word();
    logic [31:0] w;
    logic s;
    s = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0: w = 32'h0000_0000;
      1: w = 32'h7f80_0000;
      2: w = 32'h7fc0_0000 | ($urandom & 32'h003f_ffff);
      3: w = 32'h7f80_0000 | ($urandom_range(1, 32'h003f_ffff));
      4: w = $urandom & 32'h007f_ffff;
      5: w = 32'h7f7f_ffff;
      6: w = 32'h0080_0000;
      7: w = 32'h0000_0001;
      8: w = 32'h7fff_ffff;
      default: w = 32'h3f80_0000;
    endcase
    return {s, w[30:0]};
  endfunction

  function automatic logic [31:0] rand_word();
    if ($urandom_range(0, 2) == 0) return special_word();
    return $urandom;
  endfunction

  // one input transfer, with a random gap before it
  task automatic send_item(logic [3:0] act, logic [31:0] a, logic [31:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, b, a, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // receiver: random stalls with stretches of always-ready
  initial begin
    int g;
    @(posedge rst_ni);
    while (!sink_done) begin
      g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      m_axis_tready <= 1'b0;
      repeat (g) @(posedge clk_i);
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] a, b;
    logic [3:0] act;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation on edge operands, zeros of both signs, nans
    for (int op = 0; op <= 8; op++)
      send_item(4'(op), 32'h8000_0000, 32'h0000_0000);
    send_item(ActMin, 32'h7f80_0001, 32'h3f80_0000);  // signaling nan, one operand
    send_item(ActMax, 32'h7fc0_0000, 32'hffc0_0001);  // both nan
    send_item(ActMax, 32'h0000_0000, 32'h8000_0000);
    send_item(ActEq, 32'h7fc0_0000, 32'h7fc0_0000);   // quiet nan, no flag
    send_item(ActEq, 32'hff80_0001, 32'h0000_0000);   // signaling nan flags
    send_item(ActLt, 32'h7fc0_0000, 32'h0000_0000);   // any nan flags
    send_item(ActLe, 32'hff7f_ffff, 32'h7f7f_ffff);
    send_item(ActLt, 32'hffff_ffff, 32'hffff_ffff);
    send_item(ActClass, 32'hff80_0000, 32'h0);
    send_item(ActClass, 32'h8000_0001, 32'hffff_ffff);
    send_item(ActClass, 32'h7f80_0001, 32'h0);
    send_item(ActClass, 32'h0080_0000, 32'h0);
    send_item(4'd9, 32'hffff_ffff, 32'hffff_ffff);
    send_item(4'd15, 32'h1234_5678, 32'h0);

    // hold off until all expected results have arrived
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < 1450; n++) begin
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      a = rand_word();
      b = ($urandom_range(0, 7) == 0) ? a : rand_word();
      if ($urandom_range(0, 9) == 0) b = {~b[31], b[30:0]};
      send_item(act, a, b);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    sink_done = 1'b1;
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[fp32_sign_compare_classify_unit.f]
+incdir+sv
sv/fsc_pkg.sv
sv/fsc_datapath.sv
sv/fp32_sign_compare_classify_unit.sv
test/fp32_sign_compare_classify_unit_checker.sv
test/fp32_sign_compare_classify_unit_tb.sv
